>>> rtl/core/brl_pkg.sv
`timescale 1ns / 1ps

package brl_pkg;

  // Coordinate and decision widths
  localparam int COORD_BITS = 12;
  localparam int DEC_BITS   = COORD_BITS + 3;

  // Input item kinds
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_REQ  = 1'b1
  } kind_t;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  // One input transaction
  typedef struct packed {
    kind_t  kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    kind_t  kind;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    coord_t dx;
    coord_t dy;
    logic   x_neg;
    logic   y_neg;
  } cmd_t;

  // Handshake between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

>>> rtl/core/brl_front.sv
`timescale 1ns / 1ps

module brl_front import brl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output cmd_head_t head,
  input  logic      head_take
);

  cmd_t       q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd_new;
  logic       do_push, do_pop;

  // Classify: deltas and step directions for loads
  always_comb begin
    cmd_new.kind  = in_item.kind;
    cmd_new.sx    = in_item.start_x;
    cmd_new.sy    = in_item.start_y;
    cmd_new.ex    = in_item.end_x;
    cmd_new.ey    = in_item.end_y;
    cmd_new.x_neg = in_item.end_x < in_item.start_x;
    cmd_new.y_neg = in_item.end_y < in_item.start_y;
    cmd_new.dx    = cmd_new.x_neg ? in_item.start_x - in_item.end_x
                                  : in_item.end_x - in_item.start_x;
    cmd_new.dy    = cmd_new.y_neg ? in_item.start_y - in_item.end_y
                                  : in_item.end_y - in_item.start_y;
  end

  assign in_full    = (cnt_r == 2'd2);
  assign do_push    = in_push && !in_full;
  assign do_pop     = head_take && (cnt_r != 2'd0);
  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = q_r[rptr_r];

  // Queue pointers
  always_comb begin
    wptr_nxt = wptr_r ^ do_push;
    rptr_nxt = rptr_r ^ do_pop;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= cmd_new;
    end
  end

endmodule

>>> rtl/core/brl_back.sv
`timescale 1ns / 1ps

module brl_back import brl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_head_t head,
  output logic      head_take,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  // Line state
  coord_t cur_x_r, cur_x_nxt;
  coord_t cur_y_r, cur_y_nxt;
  coord_t tgt_x_r, tgt_x_nxt;
  coord_t tgt_y_r, tgt_y_nxt;
  dec_t   dec_r, dec_nxt;
  dec_t   inc_a_r, inc_a_nxt;
  dec_t   inc_b_r, inc_b_nxt;
  logic   x_neg_r, x_neg_nxt;
  logic   y_neg_r, y_neg_nxt;
  logic   steep_r, steep_nxt;
  logic   active_r, active_nxt;

  // Result queue
  out_item_t  oq_r [2];
  logic       owptr_r, orptr_r;
  logic [1:0] ocnt_r;
  logic       o_push, o_pop;
  out_item_t  o_new;

  // Load setup
  logic   ld_steep;
  coord_t ld_major, ld_minor;
  dec_t   major_e, minor_e;

  // Step controls
  logic is_last, dneg, step_x, step_y;

  assign head_take = head.valid && (ocnt_r != 2'd2);

  always_comb begin
    ld_steep = head.cmd.dy > head.cmd.dx;
    ld_major = ld_steep ? head.cmd.dy : head.cmd.dx;
    ld_minor = ld_steep ? head.cmd.dx : head.cmd.dy;
    major_e  = {{(DEC_BITS-COORD_BITS){1'b0}}, ld_major};
    minor_e  = {{(DEC_BITS-COORD_BITS){1'b0}}, ld_minor};
  end

  // Load setup, pixel emit and Bresenham step
  always_comb begin
    is_last = steep_r ? (cur_y_r == tgt_y_r) : (cur_x_r == tgt_x_r);
    dneg    = dec_r[DEC_BITS-1];
    step_x  = !steep_r || !dneg;
    step_y  = steep_r || !dneg;

    o_new.pixel_x = cur_x_r;
    o_new.pixel_y = cur_y_r;
    o_new.last    = is_last;
    o_push        = 1'b0;

    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    dec_nxt    = dec_r;
    inc_a_nxt  = inc_a_r;
    inc_b_nxt  = inc_b_r;
    x_neg_nxt  = x_neg_r;
    y_neg_nxt  = y_neg_r;
    steep_nxt  = steep_r;
    active_nxt = active_r;

    if (head_take) begin
      case (head.cmd.kind)
        KIND_LOAD: begin
          cur_x_nxt  = head.cmd.sx;
          cur_y_nxt  = head.cmd.sy;
          tgt_x_nxt  = head.cmd.ex;
          tgt_y_nxt  = head.cmd.ey;
          x_neg_nxt  = head.cmd.x_neg;
          y_neg_nxt  = head.cmd.y_neg;
          steep_nxt  = ld_steep;
          dec_nxt    = minor_e + minor_e - major_e;
          inc_a_nxt  = minor_e + minor_e;
          inc_b_nxt  = minor_e + minor_e - major_e - major_e;
          active_nxt = 1'b1;
        end
        default: begin
          if (active_r) begin
            o_push = 1'b1;
            if (is_last) begin
              active_nxt = 1'b0;
            end else begin
              if (step_x) begin
                cur_x_nxt = x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
              end
              if (step_y) begin
                cur_y_nxt = y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
              end
              dec_nxt = dneg ? dec_r + inc_a_r : dec_r + inc_b_r;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      dec_r    <= '0;
      inc_a_r  <= '0;
      inc_b_r  <= '0;
      x_neg_r  <= 1'b0;
      y_neg_r  <= 1'b0;
      steep_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      dec_r    <= dec_nxt;
      inc_a_r  <= inc_a_nxt;
      inc_b_r  <= inc_b_nxt;
      x_neg_r  <= x_neg_nxt;
      y_neg_r  <= y_neg_nxt;
      steep_r  <= steep_nxt;
      active_r <= active_nxt;
    end
  end

  // Result queue control
  assign out_empty = (ocnt_r == 2'd0);
  assign o_pop     = out_pop && !out_empty;
  assign out_item  = oq_r[orptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= 1'b0;
      orptr_r <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      owptr_r <= owptr_r ^ o_push;
      orptr_r <= orptr_r ^ o_pop;
      ocnt_r  <= ocnt_r + {1'b0, o_push} - {1'b0, o_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      oq_r[owptr_r] <= o_new;
    end
  end

endmodule

>>> rtl/core/bresenham_line_rasterizer_top.sv
`timescale 1ns / 1ps

// All-octant Bresenham line generator with queue-style ports on both sides.
// A load transaction (kind 0) latches two endpoints and sets up the line; it
// gives no result. Each request transaction (kind 1) returns the next pixel,
// first endpoint through last endpoint inclusive, with last set on the final
// one; requests while no line is active are dropped. A load always restarts.
// Throughput is one transaction per clock in steady state unless the result
// queue is full: the front stage computes deltas and step directions into a
// two-entry command queue, and the back stage performs one Bresenham step per
// cycle into a two-entry result queue; a request passes through both queues.

module bresenham_line_rasterizer_top import brl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  cmd_head_t head;
  logic      head_take;

  brl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .head      (head),
    .head_take (head_take)
  );

  brl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_take (head_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
